// ===== hw/rtl/lsc_pkg.sv =====
// shared types, constants and helper functions for the line segment clipper
// no dependencies; imported by every module of the clipper
package lsc_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 8;
  localparam int MAX_PASSES   = 8;
  localparam int PT_BITS      = COORD_BITS + FRAC_BITS;
  localparam int DIFF_BITS    = PT_BITS + 1;
  localparam int NUM_BITS     = 2 * PT_BITS + 2;
  localparam int DEN_BITS     = PT_BITS + 1;
  localparam int REM_BITS     = PT_BITS + 2;
  localparam int QUO_BITS     = PT_BITS + 1;
  localparam int DIV_STEPS    = NUM_BITS / 2;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
  localparam int PASS_BITS    = $clog2(MAX_PASSES + 1);
  localparam int QDEPTH       = 2;
  localparam int QPTR_BITS    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS    = $clog2(QDEPTH + 1);

  // outcode bits
  localparam logic [3:0] CODE_L = 4'h1;
  localparam logic [3:0] CODE_R = 4'h2;
  localparam logic [3:0] CODE_B = 4'h4;
  localparam logic [3:0] CODE_T = 4'h8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PT_BITS-1:0]    pt_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
  } seg_t;

  typedef struct packed {
    logic   visible;
    coord_t out_first_x;
    coord_t out_first_y;
    coord_t out_second_x;
    coord_t out_second_y;
  } res_t;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } win_t;

  typedef struct packed {
    seg_t seg;
    logic triv_acc;
    logic triv_rej;
  } job_t;

  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_Y_MIN = 2'd1,
    REG_X_MAX = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } bst_t;

  // integer coordinate to fixed point
  function automatic pt_t to_pt(coord_t c);
    return {c, {FRAC_BITS{1'b0}}};
  endfunction

  // window outcode of a fixed-point point
  function automatic logic [3:0] outcode(pt_t x, pt_t y, win_t w);
    logic [3:0] c;
    c = '0;
    if (x < to_pt(w.x_min)) c = c | CODE_L;
    if (x > to_pt(w.x_max)) c = c | CODE_R;
    if (y < to_pt(w.y_min)) c = c | CODE_B;
    if (y > to_pt(w.y_max)) c = c | CODE_T;
    return c;
  endfunction

  // round half up to an integer coordinate
  function automatic coord_t round_int(pt_t v);
    logic signed [PT_BITS:0] s;
    s = {v[PT_BITS-1], v} + (PT_BITS+1)'(1 << (FRAC_BITS - 1));
    return s[FRAC_BITS +: COORD_BITS];
  endfunction

endpackage

// ===== hw/rtl/lsc_front.sv =====
// front end: accepts segments, classifies trivial accept or reject, queues jobs
// depends on lsc_pkg
module lsc_front import lsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  seg_t in_data,
  input  win_t win,
  output logic job_valid,
  output job_t job,
  input  logic job_take
);

  job_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [3:0]           c1, c2;
  job_t                 job_in;
  logic                 wr_en, rd_en;

  // classify by outcodes of the raw endpoints
  always_comb begin
    c1 = outcode(to_pt(in_data.first_x), to_pt(in_data.first_y), win);
    c2 = outcode(to_pt(in_data.second_x), to_pt(in_data.second_y), win);
    job_in.seg      = in_data;
    job_in.triv_acc = ((c1 | c2) == 4'h0);
    job_in.triv_rej = ((c1 & c2) != 4'h0);
  end

  // queue control
  always_comb begin
    full       = (cnt_r == QCNT_BITS'(QDEPTH));
    job_valid  = (cnt_r != '0);
    job        = mem_r[rd_ptr_r];
    wr_en      = push && !full;
    rd_en      = job_take && job_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/lsc_back.sv =====
// back end: clip sequencer with multiplier and two-bit-per-cycle divider
// depends on lsc_pkg
module lsc_back import lsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  win_t win,
  input  logic job_valid,
  input  job_t job,
  output logic job_take,
  output logic res_push,
  output res_t res,
  input  logic res_full
);

  bst_t                    st_r, st_nxt;
  pt_t                     x1_r, y1_r, x2_r, y2_r, edge_r;
  logic [PASS_BITS-1:0]    pass_r;
  logic                    lr_r, skip_r, neg_r, zero_r, vis_r;
  diff_t                   n1_r, n2_r, den_r;
  logic [2*PT_BITS-1:0]    prod_r;
  logic [PT_BITS-1:0]      d_r;
  logic [NUM_BITS-1:0]     num_r;
  logic [REM_BITS-1:0]     rem_r;
  logic [QUO_BITS-1:0]     quo_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;

  logic [3:0]          c1, c2, sc1;
  logic                swap, lr_c, done_acc, done_rej, pass_lim;
  pt_t                 sx1, sy1, sx2, sy2, edge_c;
  diff_t               n1_c, n2_c, den_c;
  logic [PT_BITS-1:0]  a_mag, b_mag, d_mag;
  logic [REM_BITS-1:0] r1, r1s, r2, r2s, dd_ext;
  logic                ge1, ge2;
  diff_t               corr;

  // outcode evaluation, swap and edge choice
  always_comb begin
    c1       = outcode(x1_r, y1_r, win);
    c2       = outcode(x2_r, y2_r, win);
    pass_lim = (pass_r == PASS_BITS'(MAX_PASSES));
    done_acc = ((c1 | c2) == 4'h0);
    done_rej = ((c1 & c2) != 4'h0) || pass_lim;
    swap     = (c1 == 4'h0);
    sx1      = swap ? x2_r : x1_r;
    sy1      = swap ? y2_r : y1_r;
    sx2      = swap ? x1_r : x2_r;
    sy2      = swap ? y1_r : y2_r;
    sc1      = swap ? c2 : c1;
    lr_c     = ((sc1 & (CODE_L | CODE_R)) != 4'h0);
    if (lr_c) begin
      edge_c = ((sc1 & CODE_L) != 4'h0) ? to_pt(win.x_min) : to_pt(win.x_max);
      n1_c   = diff_t'(edge_c) - diff_t'(sx1);
      n2_c   = diff_t'(sy2) - diff_t'(sy1);
      den_c  = diff_t'(sx2) - diff_t'(sx1);
    end else begin
      edge_c = ((sc1 & CODE_B) != 4'h0) ? to_pt(win.y_min) : to_pt(win.y_max);
      n1_c   = diff_t'(edge_c) - diff_t'(sy1);
      n2_c   = diff_t'(sx2) - diff_t'(sx1);
      den_c  = diff_t'(sy2) - diff_t'(sy1);
    end
  end

  // operand magnitudes
  always_comb begin
    a_mag = n1_r[DIFF_BITS-1]  ? PT_BITS'(-n1_r)  : PT_BITS'(n1_r);
    b_mag = n2_r[DIFF_BITS-1]  ? PT_BITS'(-n2_r)  : PT_BITS'(n2_r);
    d_mag = den_r[DIFF_BITS-1] ? PT_BITS'(-den_r) : PT_BITS'(den_r);
  end

  // two restoring division steps per cycle
  always_comb begin
    dd_ext = REM_BITS'({d_r, 1'b0});
    r1     = {rem_r[REM_BITS-2:0], num_r[NUM_BITS-1]};
    ge1    = (r1 >= dd_ext);
    r1s    = ge1 ? r1 - dd_ext : r1;
    r2     = {r1s[REM_BITS-2:0], num_r[NUM_BITS-2]};
    ge2    = (r2 >= dd_ext);
    r2s    = ge2 ? r2 - dd_ext : r2;
  end

  // signed correction term
  always_comb begin
    if (zero_r) begin
      corr = '0;
    end else if (neg_r) begin
      corr = -diff_t'(quo_r);
    end else begin
      corr = diff_t'(quo_r);
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (job_valid) begin
          st_nxt = (job.triv_acc || job.triv_rej) ? ST_FIN : ST_CODE;
        end
      end
      ST_CODE: st_nxt = (done_acc || done_rej) ? ST_FIN : ST_MUL;
      ST_MUL:  st_nxt = ST_PREP;
      ST_PREP: st_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) st_nxt = ST_UPD;
      end
      ST_UPD:  st_nxt = ST_CODE;
      ST_FIN: begin
        if (!res_full) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    job_take = (st_r == ST_IDLE) && job_valid;
    res_push = (st_r == ST_FIN) && !res_full;
    res.visible      = vis_r;
    res.out_first_x  = vis_r ? round_int(x1_r) : '0;
    res.out_first_y  = vis_r ? round_int(y1_r) : '0;
    res.out_second_x = vis_r ? round_int(x2_r) : '0;
    res.out_second_y = vis_r ? round_int(y2_r) : '0;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        x1_r   <= to_pt(job.seg.first_x);
        y1_r   <= to_pt(job.seg.first_y);
        x2_r   <= to_pt(job.seg.second_x);
        y2_r   <= to_pt(job.seg.second_y);
        pass_r <= '0;
        vis_r  <= job.triv_acc;
      end
      ST_CODE: begin
        vis_r  <= done_acc && !pass_lim;
        if (!(done_acc || done_rej)) begin
          x1_r   <= sx1;
          y1_r   <= sy1;
          x2_r   <= sx2;
          y2_r   <= sy2;
          edge_r <= edge_c;
          lr_r   <= lr_c;
          skip_r <= !lr_c && (sx2 == sx1);
          n1_r   <= n1_c;
          n2_r   <= n2_c;
          den_r  <= den_c;
        end
      end
      ST_MUL: begin
        prod_r <= (2*PT_BITS)'(a_mag) * (2*PT_BITS)'(b_mag);
        d_r    <= d_mag;
        neg_r  <= n1_r[DIFF_BITS-1] ^ n2_r[DIFF_BITS-1] ^ den_r[DIFF_BITS-1];
        zero_r <= (den_r == '0) || (a_mag == '0) || (b_mag == '0) || skip_r;
      end
      ST_PREP: begin
        num_r <= (NUM_BITS'(prod_r) << 1) + NUM_BITS'(d_r) - NUM_BITS'(neg_r);
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        num_r <= num_r << 2;
        rem_r <= r2s;
        quo_r <= {quo_r[QUO_BITS-3:0], ge1, ge2};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_UPD: begin
        if (lr_r) begin
          y1_r <= PT_BITS'(diff_t'(y1_r) + corr);
          x1_r <= edge_r;
        end else begin
          if (!skip_r) x1_r <= PT_BITS'(diff_t'(x1_r) + corr);
          y1_r <= edge_r;
        end
        pass_r <= pass_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // a result leaves only from the finish state
  a_push_fin: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> st_r == ST_FIN) else $error("result pushed outside finish");
  // divider count stays within its step count
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> cnt_r < DIV_CNT_BITS'(DIV_STEPS)) else $error("divider overrun");
  // clip passes never exceed the limit
  a_pass_lim: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MUL |-> pass_r < PASS_BITS'(MAX_PASSES)) else $error("pass limit exceeded");
  // a job is taken only when idle, and work starts next cycle
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> (st_r == ST_CODE || st_r == ST_FIN)) else $error("bad job start");
`endif

endmodule

// ===== hw/rtl/lsc_outq.sv =====
// result queue between the clip sequencer and the result port
// depends on lsc_pkg
module lsc_outq import lsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic res_push,
  input  res_t res,
  output logic res_full,
  output logic empty,
  input  logic pop,
  output res_t out_data
);

  res_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 wr_en, rd_en;

  // queue control
  always_comb begin
    res_full   = (cnt_r == QCNT_BITS'(QDEPTH));
    empty      = (cnt_r == '0);
    out_data   = mem_r[rd_ptr_r];
    wr_en      = res_push && !res_full;
    rd_en      = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/line_segment_clipper_unit.sv =====
// Cohen-Sutherland line clipper against a window set by four write-only
// registers. Segments enter a two-deep job queue where trivial accept and
// reject are classified; the back end then clips. A trivially decided segment
// goes from idle straight to the finish state; each clip pass steps through
// outcode, multiply, dividend setup, the divider at two quotient bits per
// cycle, and update. Results wait in a two-deep queue.
// depends on lsc_pkg, lsc_front, lsc_back, lsc_outq
module line_segment_clipper_unit import lsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  seg_t     in_data,
  output logic     empty,
  input  logic     pop,
  output res_t     out_data,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_idx,
  input  coord_t   cfg_data
);

  win_t win_r;
  logic job_valid, job_take, res_push, res_full;
  job_t job;
  res_t res;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.x_min <= coord_t'(50);
      win_r.y_min <= coord_t'(50);
      win_r.x_max <= coord_t'(350);
      win_r.y_max <= coord_t'(350);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_X_MIN: win_r.x_min <= cfg_data;
        REG_Y_MIN: win_r.y_min <= cfg_data;
        REG_X_MAX: win_r.x_max <= cfg_data;
        REG_Y_MAX: win_r.y_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front end and job queue
  lsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .win       (win_r),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  // clip sequencer
  lsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win_r),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // result queue
  lsc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ===== tb/lsc_checker.sv =====
// checker for the line segment clipper: watches both channels and the register port,
// predicts each clipped segment and compares it field by field
// depends on lsc_pkg
module lsc_checker import lsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  logic     full,
  input  seg_t     in_data,
  input  logic     empty,
  input  logic     pop,
  input  res_t     out_data,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_idx,
  input  coord_t   cfg_data,
  output int       errors,
  output int       pending
);

  localparam longint FX_ONE  = 256;
  localparam longint FX_HALF = 128;

  longint win_x_lo, win_y_lo, win_x_hi, win_y_hi;
  res_t   clipped_q[$];

  // window outcode of a fixed-point point
  function automatic logic [3:0] region_of(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < win_x_lo * FX_ONE) c |= CODE_L;
    if (x > win_x_hi * FX_ONE) c |= CODE_R;
    if (y < win_y_lo * FX_ONE) c |= CODE_B;
    if (y > win_y_hi * FX_ONE) c |= CODE_T;
    return c;
  endfunction

  // n1 * n2 / den rounded to nearest on magnitudes, ties toward plus infinity, sign applied after
  function automatic longint edge_offset(longint n1, longint n2, longint den);
    bit     neg;
    longint a, b, d, q;
    if (den == 0) return 0;
    neg = (n1 < 0) ^ (n2 < 0) ^ (den < 0);
    a = (n1 < 0) ? -n1 : n1;
    b = (n2 < 0) ? -n2 : n2;
    d = (den < 0) ? -den : den;
    if (a == 0 || b == 0) return 0;
    q = (2 * a * b + d - longint'(neg)) / (2 * d);
    return neg ? -q : q;
  endfunction

  function automatic coord_t round_coord(longint v);
    longint w;
    w = (v + FX_HALF) >>> FRAC_BITS;
    return coord_t'(w);
  endfunction

  // full cohen-sutherland clip of one segment
  function automatic res_t clip_segment(seg_t s);
    longint     x1, y1, x2, y2, t, edge_pt;
    logic [3:0] c1, c2, tc;
    bit         vis;
    res_t       r;
    x1 = longint'(s.first_x) * FX_ONE;
    y1 = longint'(s.first_y) * FX_ONE;
    x2 = longint'(s.second_x) * FX_ONE;
    y2 = longint'(s.second_y) * FX_ONE;
    vis = 0;
    for (int p = 0; p < MAX_PASSES; p++) begin
      c1 = region_of(x1, y1);
      c2 = region_of(x2, y2);
      if ((c1 | c2) == 0) begin
        vis = 1;
        break;
      end
      if ((c1 & c2) != 0) break;
      if (c1 == 0) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
        tc = c1; c1 = c2; c2 = tc;
      end
      if ((c1 & (CODE_L | CODE_R)) != 0) begin
        edge_pt = (((c1 & CODE_L) != 0) ? win_x_lo : win_x_hi) * FX_ONE;
        y1 += edge_offset(edge_pt - x1, y2 - y1, x2 - x1);
        x1 = edge_pt;
      end else begin
        edge_pt = (((c1 & CODE_B) != 0) ? win_y_lo : win_y_hi) * FX_ONE;
        if (x2 != x1) x1 += edge_offset(edge_pt - y1, x2 - x1, y2 - y1);
        y1 = edge_pt;
      end
    end
    r = '0;
    r.visible = vis;
    if (vis) begin
      r.out_first_x  = round_coord(x1);
      r.out_first_y  = round_coord(y1);
      r.out_second_x = round_coord(x2);
      r.out_second_y = round_coord(y2);
    end
    return r;
  endfunction

  assign pending = clipped_q.size();

  // track window, predict on input transaction, compare on output transaction
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      win_x_lo <= 50;
      win_y_lo <= 50;
      win_x_hi <= 350;
      win_y_hi <= 350;
      clipped_q.delete();
    end else begin
      if (push && !full) clipped_q.push_back(clip_segment(in_data));
      if (pop && !empty) begin
        if (clipped_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual %p", $time, out_data);
        end else begin
          want = clipped_q.pop_front();
          if (want.visible !== out_data.visible ||
              want.out_first_x !== out_data.out_first_x ||
              want.out_first_y !== out_data.out_first_y ||
              want.out_second_x !== out_data.out_second_x ||
              want.out_second_y !== out_data.out_second_y) begin
            errors++;
            $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_X_MIN: win_x_lo <= longint'(cfg_data);
          REG_Y_MIN: win_y_lo <= longint'(cfg_data);
          REG_X_MAX: win_x_hi <= longint'(cfg_data);
          REG_Y_MAX: win_y_hi <= longint'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  initial errors = 0;

endmodule

// ===== tb/tb.sv =====
// top of the clipper testbench: clock, reset, stimulus, register writes and verdict
// depends on lsc_pkg, line_segment_clipper_unit and lsc_checker
module tb;
  import lsc_pkg::*;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     push = 0;
  logic     full, empty;
  seg_t     in_data = '0;
  logic     pop = 0;
  res_t     out_data;
  logic     cfg_we = 0;
  cfg_idx_t cfg_idx = REG_X_MIN;
  coord_t   cfg_data = '0;
  int       errors, pending;

  int       send_idle_pct = 0;
  int       drain_stall_pct = 0;
  bit       long_hold = 0;
  int       hold_cnt = 0;
  int       wx0 = 50, wy0 = 50, wx1 = 350, wy1 = 350;

  line_segment_clipper_unit uut (
    .clk, .rst_n, .push, .full, .in_data, .empty, .pop, .out_data,
    .cfg_we, .cfg_idx, .cfg_data
  );

  lsc_checker chk (
    .clk, .rst_n, .push, .full, .in_data, .empty, .pop, .out_data,
    .cfg_we, .cfg_idx, .cfg_data, .errors, .pending
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // result side: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (long_hold && hold_cnt < 500) begin
      hold_cnt <= hold_cnt + 1;
      pop <= 0;
    end else begin
      pop <= ($urandom_range(99) >= drain_stall_pct);
    end
  end

  // offer one segment, with random idle cycles ahead of it
  task automatic send_segment(int ax, int ay, int bx, int by);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1;
    in_data <= '{first_x: coord_t'(ax), first_y: coord_t'(ay),
                 second_x: coord_t'(bx), second_y: coord_t'(by)};
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
  endtask

  // window change only once all results are back
  task automatic set_window(int x0, int y0, int x1, int y1);
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_we <= 1; cfg_idx <= REG_X_MIN; cfg_data <= coord_t'(x0); @(posedge clk);
    cfg_idx <= REG_Y_MIN; cfg_data <= coord_t'(y0); @(posedge clk);
    cfg_idx <= REG_X_MAX; cfg_data <= coord_t'(x1); @(posedge clk);
    cfg_idx <= REG_Y_MAX; cfg_data <= coord_t'(y1); @(posedge clk);
    cfg_we <= 0;
    wx0 = x0; wy0 = y0; wx1 = x1; wy1 = y1;
  endtask

  function automatic int near_coord(int lo, int hi);
    int a, b;
    a = ((lo < hi) ? lo : hi) - 300;
    b = ((lo < hi) ? hi : lo) + 300;
    if (a < -2048) a = -2048;
    if (b > 2047) b = 2047;
    return $urandom_range(b - a) + a;
  endfunction

  // mostly segments around the window, some anywhere in the field range
  task automatic send_random(int n);
    repeat (n) begin
      if ($urandom_range(3) == 0)
        send_segment($urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                     $urandom_range(4095) - 2048, $urandom_range(4095) - 2048);
      else if ($urandom_range(7) == 0) begin
        int vx;
        vx = near_coord(wx0, wx1);
        send_segment(vx, near_coord(wy0, wy1), vx, near_coord(wy0, wy1));
      end else
        send_segment(near_coord(wx0, wx1), near_coord(wy0, wy1),
                     near_coord(wx0, wx1), near_coord(wy0, wy1));
    end
  endtask

  initial begin
    int idle_mode[4][2];
    idle_mode = '{'{0, 0}, '{73, 0}, '{0, 73}, '{8, 8}};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset window, extremes, trivial cases, vertical and horizontal
    send_segment(100, 100, 200, 200);
    send_segment(0, 0, 10, 10);
    send_segment(-2048, -2048, 2047, 2047);
    send_segment(2047, -2048, -2048, 2047);
    send_segment(200, -2048, 200, 2047);
    send_segment(-2048, 200, 2047, 200);
    send_segment(0, 200, 400, 201);
    send_segment(100, 100, 400, 133);
    send_segment(0, 0, 400, 400);
    send_segment(200, 200, 200, 200);
    send_segment(50, 50, 350, 350);
    send_segment(-1, -1, -1, -1);
    send_segment(30, 360, 360, 30);
    send_segment(49, 351, 351, 49);
    set_window(-2048, -2048, 2047, 2047);
    send_segment(-2048, -2048, 2047, 2047);
    send_segment(2047, 0, -2048, 0);
    set_window(300, 300, 100, 100);
    send_segment(0, 0, 400, 400);
    send_segment(200, 200, 250, 250);
    set_window(7, 7, 7, 7);
    send_segment(0, 0, 14, 14);
    send_segment(7, 7, 7, 7);

    // random phases across windows and idling modes
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_window(50, 50, 350, 350);
        1: set_window(-2048, -2048, 2047, 2047);
        2: set_window(-100, -60, 100, 60);
        3: set_window(2000, -2048, 2047, -2000);
        4: set_window(200, 200, -200, -200);
        default: set_window($urandom_range(2000) - 1000, $urandom_range(2000) - 1000,
                            $urandom_range(2000) - 1000, $urandom_range(2000) - 1000);
      endcase
      send_idle_pct = idle_mode[p % 4][0];
      drain_stall_pct = idle_mode[p % 4][1];
      if (p == 2) long_hold = 1;
      send_random(90);
      long_hold = 0;
    end
    send_idle_pct = 0;
    drain_stall_pct = 0;
    push <= 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin
    #60000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
